FILE: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the text console writer.
// Depends on nothing; the other files in rtl/core but tcw_ram.sv import it.
package tcw_pkg;

	// Operation codes carried in the func field of a command word.
	localparam logic [1:0] FUNC_PUT   = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Character codes with a special meaning for put.
	localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
	localparam logic [7:0] CHAR_TAB       = 8'd9;
	localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;

	localparam int          TAB_STEP        = 4;
	localparam logic [7:0]  BLANK_ATTR_INIT = 8'h07;
	localparam logic [15:0] RESET_CELL      = 16'h0720;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  char_code;
		logic [7:0]  char_color;
		logic [10:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [15:0] cell_value;
		logic        did_scroll;
	} rsp_t;

	// Cell write request and scroll flag produced by the cursor logic.
	typedef struct packed {
		logic       wr_en;
		logic [7:0] wr_char;
		logic       scroll;
	} put_ctl_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_FILL
	} state_t;

endpackage

FILE: rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
// Top level of the text console writer: command sequencer, cell memory and result register.
// Depends on tcw_pkg, tcw_ram and tcw_cursor.
//
//   channel  direction  handshake            word
//   cmd      in         cmd_valid/cmd_stall  tcw_pkg::cmd_t (func, char, color, index)
//   rsp      out        rsp_valid/rsp_stall  tcw_pkg::rsp_t (cursor, cell, scroll flag)
//   cfg      in         cfg_valid/cfg_ready  8-bit blank attribute
//
// A command word is taken in ST_IDLE and executed in ST_EXEC once the result register is
// free; put, clear and unknown operations load their result there, a read loads it from
// ST_READ, because the cell memory has a registered read port. The single write port of the
// cell memory blanks one cell at a time: after a scroll the COLUMNS cells of the new bottom
// line, after a clear all COLUMNS*ROWS cells. After reset it blanks all COLUMNS*ROWS cells
// (2000 by default) with cmd_stall high; configuration writes are taken throughout.
// A result waits in its own register while the next command word is already accepted.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  tcw_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tcw_pkg::rsp_t  rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [7:0]     cfg_data
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int AW1   = AW + 1;
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);

	// The grid is kept as a ring of rows. base_q is the memory address of the
	// top visible row, so a scroll only moves base_q and blanks one row.
	function automatic logic [AW-1:0] phys_addr(input logic [AW1-1:0] lin,
	                                           input logic [AW-1:0] base);
		logic [AW1-1:0] sum;
		sum = lin + {1'b0, base};
		if (sum >= AW1'(CELLS)) begin
			sum = sum - AW1'(CELLS);
		end
		return sum[AW-1:0];
	endfunction

	state_t         state_q, state_d;
	cmd_t           cmd_q, cmd_d;
	logic [CW-1:0]  col_q, col_d;
	logic [RW-1:0]  row_q, row_d;
	logic [AW-1:0]  base_q, base_d;
	logic [AW-1:0]  fill_addr_q, fill_addr_d;
	logic [AW-1:0]  fill_end_q, fill_end_d;
	logic [15:0]    fill_val_q, fill_val_d;
	logic [7:0]     blank_q;
	logic           oob_q, oob_d;
	logic           rsp_valid_q;
	rsp_t           rsp_q, rsp_d;
	logic           load_rsp;
	logic           rsp_free;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [15:0]    ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [15:0]    ram_rdata;

	logic [CW-1:0]  put_wr_col;
	logic [CW-1:0]  put_col;
	logic [RW-1:0]  put_row;
	put_ctl_t       put_ctl;
	logic [AW-1:0]  put_addr;
	logic           rd_in_range;
	logic [15:0]    blank_cell;

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_cursor (
		.char_code (cmd_q.char_code),
		.col       (col_q),
		.row       (row_q),
		.wr_col    (put_wr_col),
		.next_col  (put_col),
		.next_row  (put_row),
		.ctl       (put_ctl)
	);

	assign put_addr    = phys_addr(AW1'(row_q) * AW1'(COLUMNS) + AW1'(put_wr_col), base_q);
	assign rd_in_range = (32'(cmd_q.cell_index) < CELLS);
	assign ram_raddr   = phys_addr(AW1'(cmd_q.cell_index), base_q);
	assign blank_cell  = {blank_q, CHAR_SPACE};
	assign rsp_free    = !rsp_valid_q || !rsp_stall;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The attribute register may be written at any time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= BLANK_ATTR_INIT;
		end else if (cfg_valid && cfg_ready) begin
			blank_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			col_q       <= '0;
			row_q       <= '0;
			base_q      <= '0;
			fill_addr_q <= '0;
			fill_end_q  <= AW'(CELLS - 1);
			fill_val_q  <= RESET_CELL;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			col_q       <= col_d;
			row_q       <= row_d;
			base_q      <= base_d;
			fill_addr_q <= fill_addr_d;
			fill_end_q  <= fill_end_d;
			fill_val_q  <= fill_val_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		oob_q <= oob_d;
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		col_d       = col_q;
		row_d       = row_q;
		base_d      = base_q;
		fill_addr_d = fill_addr_q;
		fill_end_d  = fill_end_q;
		fill_val_d  = fill_val_q;
		oob_d       = oob_q;
		ram_we      = 1'b0;
		ram_waddr   = fill_addr_q;
		ram_wdata   = fill_val_q;
		ram_re      = 1'b0;
		load_rsp    = 1'b0;
		rsp_d       = '0;

		unique case (state_q)
			ST_INIT, ST_FILL: begin
				// Blanking sweep, one cell per cycle.
				ram_we      = 1'b1;
				fill_addr_d = fill_addr_q + AW'(1);
				if (fill_addr_q == fill_end_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_d   = cmd;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// Everything happens once the result register can take the result.
				if (rsp_free) begin
					state_d = ST_IDLE;
					unique case (cmd_q.func)
						FUNC_PUT: begin
							ram_we           = put_ctl.wr_en;
							ram_waddr        = put_addr;
							ram_wdata        = {cmd_q.char_color, put_ctl.wr_char};
							col_d            = put_col;
							row_d            = put_row;
							load_rsp         = 1'b1;
							rsp_d.did_scroll = put_ctl.scroll;
							if (put_ctl.scroll) begin
								// The old top row becomes the new bottom row.
								fill_addr_d = base_q;
								fill_end_d  = base_q + AW'(COLUMNS - 1);
								fill_val_d  = blank_cell;
								if (base_q == AW'(CELLS - COLUMNS)) begin
									base_d = '0;
								end else begin
									base_d = base_q + AW'(COLUMNS);
								end
								state_d = ST_FILL;
							end
						end
						FUNC_CLEAR: begin
							col_d       = '0;
							row_d       = '0;
							base_d      = '0;
							fill_addr_d = '0;
							fill_end_d  = AW'(CELLS - 1);
							fill_val_d  = blank_cell;
							load_rsp    = 1'b1;
							state_d     = ST_FILL;
						end
						FUNC_READ: begin
							ram_re  = 1'b1;
							oob_d   = !rd_in_range;
							state_d = ST_READ;
						end
						default: begin
							// Unused operation: report the cursor and change nothing.
							load_rsp = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				if (rsp_free) begin
					load_rsp         = 1'b1;
					rsp_d.cell_value = oob_q ? 16'h0000 : ram_rdata;
					state_d          = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		rsp_d.cursor_col = 7'(32'(col_d));
		rsp_d.cursor_row = 5'(32'(row_d));
	end

	// The cursor never leaves the grid.
	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
		else $error("cursor outside the grid");

	// A result that reports a scroll is always followed by the row blanking sweep.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && load_rsp && rsp_d.did_scroll) |=> (state_q == ST_FILL))
		else $error("scroll without blanking of the bottom row");

	// A blanking sweep never runs past its last cell.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT || state_q == ST_FILL) |-> (fill_addr_q <= fill_end_q))
		else $error("blanking sweep beyond its end");

	// A new result is never loaded over one that is still stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !load_rsp)
		else $error("pending result overwritten");

endmodule

FILE: rtl/core/tcw_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/tcw_cursor.sv
`timescale 1ns / 1ps
// Cursor update for a put operation: next position, cell write and scroll flag.
// Depends on tcw_pkg.
module tcw_cursor #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	localparam int CW = $clog2(COLUMNS),
	localparam int RW = $clog2(ROWS)
) (
	input  logic [7:0]         char_code,
	input  logic [CW-1:0]      col,
	input  logic [RW-1:0]      row,
	output logic [CW-1:0]      wr_col,
	output logic [CW-1:0]      next_col,
	output logic [RW-1:0]      next_row,
	output tcw_pkg::put_ctl_t  ctl
);
	import tcw_pkg::*;

	localparam int CW1 = CW + 1;
	localparam int RW1 = RW + 1;

	logic [CW1-1:0] col_ext;
	logic [CW1-1:0] col_inc;
	logic [CW1-1:0] tab_col;
	logic [CW1-1:0] col_n;
	logic [RW1-1:0] row_n;
	logic           newl;

	assign col_ext = {1'b0, col};
	assign col_inc = col_ext + CW1'(1);
	assign tab_col = (col_ext + CW1'(TAB_STEP)) & ~CW1'(TAB_STEP - 1);

	always_comb begin
		newl        = 1'b0;
		col_n       = col_ext;
		wr_col      = col;
		ctl.wr_en   = 1'b0;
		ctl.wr_char = char_code;
		unique case (char_code)
			CHAR_NEWLINE: begin
				newl = 1'b1;
			end
			CHAR_BACKSPACE: begin
				// At column 0 a backspace changes nothing.
				if (col != '0) begin
					col_n       = col_ext - CW1'(1);
					wr_col      = col - CW'(1);
					ctl.wr_en   = 1'b1;
					ctl.wr_char = CHAR_SPACE;
				end
			end
			CHAR_TAB: begin
				if (tab_col >= CW1'(COLUMNS)) begin
					newl = 1'b1;
				end else begin
					col_n = tab_col;
				end
			end
			default: begin
				ctl.wr_en = 1'b1;
				if (col_inc >= CW1'(COLUMNS)) begin
					newl = 1'b1;
				end else begin
					col_n = col_inc;
				end
			end
		endcase

		row_n = {1'b0, row};
		if (newl) begin
			col_n = '0;
			row_n = {1'b0, row} + RW1'(1);
		end

		ctl.scroll = (row_n >= RW1'(ROWS));
		next_col   = col_n[CW-1:0];
		next_row   = ctl.scroll ? RW'(ROWS - 1) : row_n[RW-1:0];
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer: directed and random console traffic.
// Depends on tcw_pkg and the text_console_writer RTL; it carries its own model of the grid.
module testbench;
	import tcw_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLUMNS * ROWS;

	// The fourth func encoding is not an operation; the block must leave its state alone.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// A clear walks the whole grid with the input stalled, so quiet stretches are normal.
	// The watchdog fires well beyond the longest of those plus the long receiver hold-off.
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_OPS = 1600;
	localparam int PHASES = 6;

	// Receiver stall patterns; the receiver switches among them on its own schedule.
	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_LIGHT,
		FLOW_HEAVY,
		FLOW_ALTERNATE
	} flow_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd_word = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = 8'h00;

	// Model of the console: the cell grid, the cursor and the blank attribute register.
	logic [15:0] screen_model [CELLS];
	logic [6:0] cur_col;
	logic [4:0] cur_row;
	logic [7:0] blank_attr;

	// Result words that the block still owes, oldest first.
	rsp_t console_reports [$];

	int errors = 0;
	int ops_sent = 0;

	// Sender burst control.
	bit gaps_on = 1'b1;
	int burst_left = 1;

	// Receiver control. The test raises hold_off_req; the receiver takes it and then
	// counts the hold-off down itself.
	bit hold_off_req = 1'b0;
	int stall_hold = 0;
	int mode_left = 0;
	flow_t stall_mode = FLOW_FREE;

	text_console_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Put the model into its reset state: every cell a gray-on-black space, cursor home.
	task automatic reset_console_model();
		for (int i = 0; i < CELLS; i++) begin
			screen_model[i] = RESET_CELL;
		end
		cur_col = '0;
		cur_row = '0;
		blank_attr = BLANK_ATTR_INIT;
	endtask

	// Apply one operation to the model and return the result word it must produce.
	function automatic rsp_t apply_console_op(input cmd_t op);
		rsp_t rep;
		logic [15:0] blank;
		int at;
		rep = '0;
		blank = {blank_attr, CHAR_SPACE};
		at = int'(cur_row) * COLUMNS + int'(cur_col);
		case (op.func)
			FUNC_PUT: begin
				if (op.char_code == CHAR_NEWLINE) begin
					cur_col = '0;
					cur_row = cur_row + 5'd1;
				end else if (op.char_code == CHAR_BACKSPACE) begin
					// At column 0 a backspace does nothing at all.
					if (cur_col != 0) begin
						cur_col = cur_col - 7'd1;
						screen_model[at - 1] = {op.char_color, CHAR_SPACE};
					end
				end else if (op.char_code == CHAR_TAB) begin
					cur_col = (cur_col + 7'(TAB_STEP)) & ~7'(TAB_STEP - 1);
					if (cur_col >= COLUMNS) begin
						cur_col = '0;
						cur_row = cur_row + 5'd1;
					end
				end else begin
					screen_model[at] = {op.char_color, op.char_code};
					cur_col = cur_col + 7'd1;
					if (cur_col >= COLUMNS) begin
						cur_col = '0;
						cur_row = cur_row + 5'd1;
					end
				end
				// Running off the bottom shifts everything up a line and blanks the last one.
				if (cur_row >= ROWS) begin
					for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
						screen_model[i] = screen_model[i + COLUMNS];
					end
					for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
						screen_model[i] = blank;
					end
					cur_row = 5'(ROWS - 1);
					rep.did_scroll = 1'b1;
				end
			end
			FUNC_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					screen_model[i] = blank;
				end
				cur_col = '0;
				cur_row = '0;
			end
			FUNC_READ: begin
				// Indexes past the grid read as zero.
				if (op.cell_index < CELLS) begin
					rep.cell_value = screen_model[op.cell_index];
				end
			end
			default: begin
			end
		endcase
		rep.cursor_col = cur_col;
		rep.cursor_row = cur_row;
		return rep;
	endfunction

	function automatic cmd_t make_op(input logic [1:0] f, input logic [7:0] ch,
			input logic [7:0] color, input logic [10:0] idx);
		cmd_t op;
		op.func = f;
		op.char_code = ch;
		op.char_color = color;
		op.cell_index = idx;
		return op;
	endfunction

	// Any byte that the console stores as a character rather than acting on.
	function automatic logic [7:0] random_glyph();
		logic [7:0] ch;
		do begin
			ch = 8'($urandom_range(0, 255));
		end while (ch == CHAR_NEWLINE || ch == CHAR_BACKSPACE || ch == CHAR_TAB);
		return ch;
	endfunction

	// Reads mostly land on the grid, often on the cursor's own row, and now and then
	// past its end.
	function automatic logic [10:0] pick_read_index();
		int p;
		p = $urandom_range(0, 19);
		if (p < 3) begin
			return 11'($urandom_range(CELLS, 2047));
		end else if (p < 9) begin
			return 11'(int'(cur_row) * COLUMNS + $urandom_range(0, COLUMNS - 1));
		end
		return 11'($urandom_range(0, CELLS - 1));
	endfunction

	// Offer one command word and hold it until the block takes it. The model is updated
	// at the accepting edge. While gaps are on, valid drops for a random gap between bursts.
	task automatic issue_op(input cmd_t op);
		cmd_word <= op;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall !== 1'b0) begin
			@(posedge clk);
		end
		console_reports.push_back(apply_console_op(op));
		if (op.func != FUNC_UNUSED) begin
			ops_sent++;
		end
		burst_left--;
		if (burst_left <= 0) begin
			if (gaps_on) begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
	endtask

	// Stop offering and wait until every result word owed has come back. The task always
	// waits on a clock edge, so whatever the caller drives next lands in a later time step.
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (console_reports.size() != 0);
	endtask

	// Write the blank attribute register. Only called once no result word is outstanding.
	task automatic write_blank_attr(input logic [7:0] attr);
		cfg_data <= attr;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (cfg_ready !== 1'b1) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		blank_attr = attr;
	endtask

	task automatic compare_report(input rsp_t got);
		rsp_t want;
		if (console_reports.size() == 0) begin
			$error("result word %h arrived with nothing outstanding", got);
			errors++;
		end else begin
			want = console_reports.pop_front();
			if (got.cursor_col !== want.cursor_col) begin
				$error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
				errors++;
			end
			if (got.cursor_row !== want.cursor_row) begin
				$error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
				errors++;
			end
			if (got.cell_value !== want.cell_value) begin
				$error("cell_value: expected %h, got %h", want.cell_value, got.cell_value);
				errors++;
			end
			if (got.did_scroll !== want.did_scroll) begin
				$error("did_scroll: expected %0d, got %0d", want.did_scroll, got.did_scroll);
				errors++;
			end
		end
	endtask

	// Receiver: checks each accepted result word, then decides next cycle's stall. A
	// requested hold-off overrides the pattern and is counted down here.
	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			compare_report(rsp_word);
		end
		if (stall_hold > 0) begin
			stall_hold--;
			rsp_stall <= 1'b1;
		end else if (hold_off_req) begin
			hold_off_req = 1'b0;
			stall_hold = HOLD_OFF_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = flow_t'($urandom_range(0, 3));
				mode_left = $urandom_range(32, 400);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				FLOW_FREE: rsp_stall <= 1'b0;
				FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
				FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
				FLOW_ALTERNATE: rsp_stall <= ~rsp_stall;
			endcase
		end
	end

	// Watchdog: ends the run if no word moves on any channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
					(cfg_valid && cfg_ready === 1'b1)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("testbench NOT OK");
		$finish;
	end

	// Right after reset the grid holds gray spaces; reads past the grid give zero and the
	// unused operation only reports the cursor. These words also wait out the clearing
	// pass that follows reset.
	task automatic test_reset_state();
		issue_op(make_op(FUNC_READ, 8'($urandom), 8'($urandom), 11'd0));
		issue_op(make_op(FUNC_READ, 8'($urandom), 8'($urandom), 11'(CELLS - 1)));
		issue_op(make_op(FUNC_READ, 8'($urandom), 8'($urandom), 11'(CELLS)));
		issue_op(make_op(FUNC_READ, 8'($urandom), 8'($urandom), 11'h7FF));
		issue_op(make_op(FUNC_UNUSED, 8'hFF, 8'hFF, 11'h7FF));
		wait_idle();
	endtask

	// Ordinary bytes at both ends of the range and above 127, backspace in the middle of
	// a line and at column 0, tab stops and newline.
	task automatic test_put_specials();
		issue_op(make_op(FUNC_PUT, 8'h00, 8'h00, 11'd0));
		issue_op(make_op(FUNC_PUT, 8'hFF, 8'hFF, 11'h7FF));
		issue_op(make_op(FUNC_PUT, 8'h80, 8'h5A, 11'h2AA));
		issue_op(make_op(FUNC_PUT, 8'h7F, 8'hA5, 11'h555));
		issue_op(make_op(FUNC_PUT, CHAR_BACKSPACE, 8'h1E, 11'd0));
		issue_op(make_op(FUNC_READ, 8'h00, 8'h00, 11'd3));
		issue_op(make_op(FUNC_PUT, CHAR_TAB, 8'h00, 11'd0));
		issue_op(make_op(FUNC_PUT, CHAR_TAB, 8'h00, 11'd0));
		issue_op(make_op(FUNC_PUT, CHAR_NEWLINE, 8'h00, 11'd0));
		issue_op(make_op(FUNC_PUT, CHAR_BACKSPACE, 8'h33, 11'd0));
		issue_op(make_op(FUNC_READ, 8'h00, 8'h00, 11'd1));
		issue_op(make_op(FUNC_READ, 8'h00, 8'h00, 11'd2));
		wait_idle();
	endtask

	// Clear fills the grid with spaces in the configured attribute, at both extremes.
	task automatic test_blank_attribute();
		write_blank_attr(8'hFF);
		issue_op(make_op(FUNC_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom)));
		issue_op(make_op(FUNC_READ, 8'h00, 8'h00, 11'd0));
		issue_op(make_op(FUNC_READ, 8'h00, 8'h00, 11'(CELLS - 1)));
		wait_idle();
		write_blank_attr(8'h00);
		issue_op(make_op(FUNC_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom)));
		issue_op(make_op(FUNC_READ, 8'h00, 8'h00, 11'd500));
		wait_idle();
	endtask

	// One stretch of console traffic. Most are well-formed runs (text lines, tab runs,
	// backspaces, newline runs that may scroll, reads); the rest is noise or a clear and read.
	task automatic emit_sequence();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			n = $urandom_range(1, 90);
			repeat (n) issue_op(make_op(FUNC_PUT, random_glyph(), 8'($urandom), 11'($urandom)));
			if ($urandom_range(0, 9) < 7) begin
				issue_op(make_op(FUNC_PUT, CHAR_NEWLINE, 8'($urandom), 11'($urandom)));
			end
		end else if (pick < 52) begin
			n = $urandom_range(1, 24);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0) begin
					issue_op(make_op(FUNC_PUT, random_glyph(), 8'($urandom), 11'($urandom)));
				end
				issue_op(make_op(FUNC_PUT, CHAR_TAB, 8'($urandom), 11'($urandom)));
			end
		end else if (pick < 62) begin
			n = $urandom_range(0, 6);
			repeat (n) issue_op(make_op(FUNC_PUT, random_glyph(), 8'($urandom), 11'($urandom)));
			n = $urandom_range(1, 10);
			repeat (n) issue_op(make_op(FUNC_PUT, CHAR_BACKSPACE, 8'($urandom), 11'($urandom)));
		end else if (pick < 74) begin
			n = $urandom_range(1, 30);
			repeat (n) issue_op(make_op(FUNC_PUT, CHAR_NEWLINE, 8'($urandom), 11'($urandom)));
		end else if (pick < 88) begin
			n = $urandom_range(1, 8);
			repeat (n) issue_op(make_op(FUNC_READ, 8'($urandom), 8'($urandom), pick_read_index()));
		end else if (pick < 97) begin
			n = $urandom_range(1, 6);
			repeat (n) issue_op(make_op(2'($urandom), 8'($urandom), 8'($urandom), 11'($urandom)));
		end else begin
			issue_op(make_op(FUNC_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom)));
			issue_op(make_op(FUNC_READ, 8'($urandom), 8'($urandom), pick_read_index()));
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering back to
	// back, so the block fills up and has to stall its input.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_off_req = 1'b1;
		repeat (40) begin
			if ($urandom_range(0, 3) == 0) begin
				issue_op(make_op(FUNC_READ, 8'($urandom), 8'($urandom), pick_read_index()));
			end else begin
				issue_op(make_op(FUNC_PUT, random_glyph(), 8'($urandom), 11'($urandom)));
			end
		end
		gaps_on = 1'b1;
		wait_idle();
	endtask

	// Random traffic in phases, each with its own blank attribute. The sender waits for every
	// owed result word before each register write; one phase runs without sender gaps.
	task automatic test_random_traffic();
		logic [7:0] phase_attr [PHASES];
		int start;
		phase_attr = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h00, 8'h07};
		phase_attr[4] = 8'($urandom);
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			write_blank_attr(phase_attr[ph]);
			gaps_on = (ph != 1);
			start = ops_sent;
			while (ops_sent - start < RANDOM_OPS / PHASES) begin
				emit_sequence();
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		reset_console_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_put_specials();
		test_blank_attribute();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		// Wait out DRAIN_CYCLES more so that any stray result word still shows up.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && console_reports.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_cursor.sv
rtl/core/text_console_writer.sv
sim/testbench.sv
